>>> src/cbad_pkg.sv
// Shared types and constants for the cartridge bus address decoder.
// No dependencies; used by every module in src.
package cbad_pkg;

    localparam int OFFSET_W = 22;
    localparam int ROM_W    = 24;
    localparam int SAVE_W   = 19;
    localparam int CFG_IDX_W = 2;

    // region codes
    localparam logic [2:0] RG_OPEN  = 3'd0;
    localparam logic [2:0] RG_WRAM  = 3'd1;
    localparam logic [2:0] RG_VIDEO = 3'd2;
    localparam logic [2:0] RG_CPU   = 3'd3;
    localparam logic [2:0] RG_ROM   = 3'd4;
    localparam logic [2:0] RG_SAVE  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOROM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MASK  = 2'd2;

    localparam logic [ROM_W-1:0]  ROM_BYTES_RST    = 24'h100000;
    localparam logic [ROM_W-1:0]  LOROM_WIDE_LIMIT = 24'h200000;
    localparam logic [6:0]        WRAM_BANK_PAIR   = 7'h3F;  // banks 7E-7F
    localparam logic [6:0]        LOROM_BANK_WIDE  = 7'h7F;
    localparam logic [6:0]        LOROM_BANK_NARROW = 7'h3F;

    typedef struct packed {
        logic [23:0] bus_address;
        logic        is_write;
    } t_cmd;

    typedef struct packed {
        logic [2:0]          region;
        logic [OFFSET_W-1:0] phys_offset;
        logic                write_ignored;
    } t_result;

    typedef struct packed {
        logic             lorom_mode;
        logic [ROM_W-1:0] rom_bytes;
        logic [SAVE_W-1:0] save_mask;
    } t_cfg;

    // classified item between front and back; offset holds the linear ROM
    // offset when is_rom is set, the final offset otherwise
    typedef struct packed {
        logic [2:0]          region;
        logic [OFFSET_W-1:0] offset;
        logic                write_ignored;
        logic                is_rom;
    } t_work;

endpackage

>>> src/cbad_front.sv
// Front end: registers an accepted address and classifies it into region,
// offset and ignored-write flag. Depends on cbad_pkg.
module cbad_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  cbad_pkg::t_cmd  i_cmd,
    input  cbad_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output cbad_pkg::t_work o_work
);

    logic [7:0]      bank;
    logic [15:0]     low;
    logic            sys;
    logic [6:0]      lo_mask;
    logic [18:0]     lo_save;
    logic [18:0]     hi_save;
    cbad_pkg::t_work n_work;
    logic            r_valid;
    cbad_pkg::t_work r_work;

    assign bank    = i_cmd.bus_address[23:16];
    assign low     = i_cmd.bus_address[15:0];
    assign sys     = ~bank[6];
    assign lo_mask = (i_cfg.rom_bytes > cbad_pkg::LOROM_WIDE_LIMIT) ?
                     cbad_pkg::LOROM_BANK_WIDE : cbad_pkg::LOROM_BANK_NARROW;
    assign lo_save = {bank[3:0], low[14:0]} & i_cfg.save_mask;
    assign hi_save = {1'b0, bank[4:0], low[12:0]} & i_cfg.save_mask;

    always_comb begin
        n_work.region = cbad_pkg::RG_OPEN;
        n_work.offset = '0;
        n_work.is_rom = 1'b0;
        if (bank[7:1] == cbad_pkg::WRAM_BANK_PAIR) begin
            n_work.region = cbad_pkg::RG_WRAM;
            n_work.offset = {5'd0, bank[0], low};
        end else if (sys && low < 16'h2000) begin
            n_work.region = cbad_pkg::RG_WRAM;
            n_work.offset = {9'd0, low[12:0]};
        end else if (sys && low < 16'h4000) begin
            n_work.region = cbad_pkg::RG_VIDEO;
            n_work.offset = {6'd0, low};
        end else if (sys && low < 16'h6000) begin
            n_work.region = cbad_pkg::RG_CPU;
            n_work.offset = {6'd0, low};
        end else if (i_cfg.lorom_mode) begin
            if (low[15]) begin
                n_work.region = cbad_pkg::RG_ROM;
                n_work.offset = {bank[6:0] & lo_mask, low[14:0]};
                n_work.is_rom = 1'b1;
            end else if (bank[6:4] == 3'b111) begin
                n_work.region = cbad_pkg::RG_SAVE;
                n_work.offset = {3'd0, lo_save};
            end
        end else if (!sys || low[15]) begin
            n_work.region = cbad_pkg::RG_ROM;
            n_work.offset = {bank[5:0], low};
            n_work.is_rom = 1'b1;
        end else if (low[14:13] == 2'b11 && bank[5]) begin
            // HiROM save window at 6000-7FFF of banks 20-3F / A0-BF
            n_work.region = cbad_pkg::RG_SAVE;
            n_work.offset = {3'd0, hi_save};
        end
        n_work.write_ignored = i_cmd.is_write &&
            (n_work.region == cbad_pkg::RG_ROM || n_work.region == cbad_pkg::RG_OPEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
        if (i_accept) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

>>> src/cbad_queue.sv
// Two-entry queue between the classifier and the ROM reduction pipeline.
// Depends on cbad_pkg.
module cbad_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbad_pkg::t_work i_work,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output cbad_pkg::t_work o_work
);

    cbad_pkg::t_work r_slot [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = i_pop && !o_empty;
    assign o_work  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

>>> src/cbad_back.sv
// Back end: restoring remainder pipeline, one dividend bit per stage, that
// reduces ROM offsets modulo the ROM size; then the result register.
// Depends on cbad_pkg.
module cbad_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  cbad_pkg::t_work              i_work,
    input  logic [cbad_pkg::ROM_W-1:0]   i_rom_bytes,
    output logic                         o_valid,
    output cbad_pkg::t_result            o_result
);

    localparam int STAGES = cbad_pkg::OFFSET_W;

    logic                        r_vld  [STAGES];
    cbad_pkg::t_work             r_item [STAGES];
    logic [cbad_pkg::ROM_W-1:0]  r_rem  [STAGES];
    logic                        r_out_valid;
    cbad_pkg::t_result           r_out;
    cbad_pkg::t_work             last;
    logic [cbad_pkg::OFFSET_W-1:0] n_offset;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            logic                        in_vld;
            cbad_pkg::t_work             in_item;
            logic [cbad_pkg::ROM_W-1:0]  in_rem;
            logic [cbad_pkg::ROM_W:0]    trial;
            logic [cbad_pkg::ROM_W-1:0]  n_rem;

            if (k == 0) begin : g_first
                assign in_vld  = i_valid;
                assign in_item = i_work;
                assign in_rem  = '0;
            end else begin : g_next
                assign in_vld  = r_vld[k-1];
                assign in_item = r_item[k-1];
                assign in_rem  = r_rem[k-1];
            end

            // remainder stays below the divisor, so one subtract suffices
            assign trial = {in_rem, in_item.offset[STAGES-1-k]};
            assign n_rem = (trial >= {1'b0, i_rom_bytes}) ?
                           cbad_pkg::ROM_W'(trial - {1'b0, i_rom_bytes}) :
                           trial[cbad_pkg::ROM_W-1:0];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= in_vld;
                end
                r_item[k] <= in_item;
                r_rem[k]  <= n_rem;
            end
        end
    endgenerate

    assign last = r_item[STAGES-1];

    always_comb begin
        if (!last.is_rom) begin
            n_offset = last.offset;
        end else if (i_rom_bytes == '0) begin
            n_offset = '0;
        end else begin
            n_offset = r_rem[STAGES-1][cbad_pkg::OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld[STAGES-1];
        end
        r_out.region        <= last.region;
        r_out.phys_offset   <= n_offset;
        r_out.write_ignored <= last.write_ignored;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.region <= cbad_pkg::RG_SAVE)
        else $error("undefined region code");

    a_ignored_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.write_ignored) |->
        (o_result.region == cbad_pkg::RG_ROM || o_result.region == cbad_pkg::RG_OPEN))
        else $error("ignored write outside ROM or open space");

    a_open_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.region == cbad_pkg::RG_OPEN) |-> o_result.phys_offset == '0)
        else $error("open space with nonzero offset");

endmodule

>>> src/cartridge_bus_address_decoder.sv
// Top level of the cartridge bus address decoder: configuration registers,
// classifier, queue and ROM reduction pipeline. Depends on cbad_pkg,
// cbad_front, cbad_queue and cbad_back.
//
// Usage:
//   Command channel: an address is taken at a rising edge with start high and
//   busy low. busy only rises if the internal queue fills, which the
//   back end prevents by draining one item every cycle, so an address can be
//   issued in every cycle (one item per cycle sustained).
//   Result channel: o_result_valid is high for one cycle with o_result; the
//   receiver cannot hold results off. Results keep command order.
//   An accepted address reaches the strobe through the classifier register,
//   a queue slot, the 22 remainder stages (one offset bit per stage) and the
//   output register.
//   Configuration channel: i_cfg_valid/o_cfg_ready with register index and
//   data; ready is always high, unknown indexes are dropped. Write only while
//   no item is in flight.
//   Reset (synchronous, active low) empties the pipeline and loads LoROM
//   layout, a 1 MiB ROM and a zero save mask.
module cartridge_bus_address_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cbad_pkg::t_cmd                      i_cmd,
    output logic                                o_result_valid,
    output cbad_pkg::t_result                   o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cbad_pkg::ROM_W-1:0]          i_cfg_data
);

    cbad_pkg::t_cfg  r_cfg;
    cbad_pkg::t_cfg  n_cfg;
    logic            accept;
    logic            front_valid;
    cbad_pkg::t_work front_work;
    logic            q_empty;
    logic            q_full;
    cbad_pkg::t_work q_work;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign accept      = start && !busy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                cbad_pkg::CFG_LOROM_MODE: n_cfg.lorom_mode = i_cfg_data[0];
                cbad_pkg::CFG_ROM_BYTES:  n_cfg.rom_bytes  = i_cfg_data;
                cbad_pkg::CFG_SAVE_MASK:  n_cfg.save_mask  = i_cfg_data[cbad_pkg::SAVE_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lorom_mode <= 1'b1;
            r_cfg.rom_bytes  <= cbad_pkg::ROM_BYTES_RST;
            r_cfg.save_mask  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cbad_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .i_cfg    (r_cfg),
        .o_valid  (front_valid),
        .o_work   (front_work)
    );

    cbad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_work  (front_work),
        .i_pop   (1'b1),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_work  (q_work)
    );

    cbad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_work      (q_work),
        .i_rom_bytes (r_cfg.rom_bytes),
        .o_valid     (o_result_valid),
        .o_result    (o_result)
    );

endmodule
